>>> hw/rtl/swzd_pkg.sv
// Shared types, constants and codes of the sliding-window z-score detector.
package swzd_pkg;

  localparam int WIN_MAX = 128;
  localparam int WIN_AW  = $clog2(WIN_MAX);
  localparam int CNT_W   = 8;
  localparam int MUL_AW  = 128;
  localparam int MUL_BW  = 68;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 16;

  localparam logic [15:0] THR_RESET  = 16'd768;
  localparam logic [15:0] THR_DFLT   = 16'd768;
  localparam logic [7:0]  WLEN_RESET = 8'd100;
  localparam logic [7:0]  WLEN_DFLT  = 8'd100;
  localparam logic [7:0]  WLEN_CAP   = 8'(WIN_MAX);

  localparam logic [CFG_IW-1:0] CFG_THRESHOLD     = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_WINDOW_LENGTH = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_DETECT_ENABLE = 2'd2;

  localparam logic [1:0] SEV_NONE     = 2'd0;
  localparam logic [1:0] SEV_WARNING  = 2'd1;
  localparam logic [1:0] SEV_CRITICAL = 2'd2;

  typedef logic [MUL_AW-1:0] mul_a_t;
  typedef logic [MUL_BW-1:0] mul_b_t;

  typedef enum logic [5:0] {
    OP_NOP, OP_LATCH, OP_RD_OLD, OP_SUB_OLD, OP_QSUB, OP_PUSH, OP_QADD,
    OP_MUL_NQ, OP_D_SET, OP_MUL_SS, OP_D_SUB, OP_SQ_INIT, OP_SQ_STEP,
    OP_DIV_STD_INIT, OP_DIV_STEP, OP_STD_SET, OP_DIV_MEAN_INIT, OP_MEAN_SET,
    OP_MUL_NX, OP_A_SET, OP_MUL_AA, OP_L_SET, OP_MUL_TT, OP_T2_SET,
    OP_MUL_DT, OP_R_SET, OP_SC_INIT, OP_MUL_M, OP_M_SET, OP_MUL_MM,
    OP_M2_SET, OP_MUL_MD, OP_SC_STEP, OP_OUT
  } dp_op_t;

  typedef enum logic [5:0] {
    S_IDLE, S_DISP, S_RD, S_OLD, S_OLDW, S_PUSH, S_PUSHW, S_STATS, S_NQW,
    S_SS, S_SSW, S_SQI, S_SQ, S_DVI, S_DVS, S_STD, S_DVM, S_DVMS, S_MEAN,
    S_NX, S_NXW, S_AA, S_AAW, S_TT, S_TTW, S_DT, S_DTW, S_DEC, S_SCI,
    S_M, S_MW, S_MM, S_MMW, S_MD, S_MDW, S_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic mul_busy;
    logic mode;
    logic full;
    logic n_zero;
    logic ev_cand;
    logic warn;
    logic iter_last;
    logic out_free;
  } dp_status_t;

endpackage

>>> hw/rtl/swzd_in_if.sv
// Input channel: mode and sample with valid/ready.
interface swzd_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [23:0] sample;
  modport source(output valid, mode, sample, input ready);
  modport sink(input valid, mode, sample, output ready);
endinterface

>>> hw/rtl/swzd_out_if.sv
// Result channel: detection result and window statistics with valid/ready.
interface swzd_out_if;
  logic               valid;
  logic               ready;
  logic               anomaly;
  logic [1:0]         severity;
  logic [31:0]        evt_id;
  logic [15:0]        score;
  logic signed [23:0] mean;
  logic [23:0]        std_dev;
  logic [7:0]         fill;
  logic [31:0]        evt_total;
  logic [31:0]        crit_total;
  modport source(output valid, anomaly, severity, evt_id, score, mean, std_dev, fill,
                 evt_total, crit_total, input ready);
  modport sink(input valid, anomaly, severity, evt_id, score, mean, std_dev, fill,
               evt_total, crit_total, output ready);
endinterface

>>> hw/rtl/swzd_cfg_if.sv
// Configuration write channel: register index and data with valid/ready.
interface swzd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [swzd_pkg::CFG_IW-1:0] index;
  logic [swzd_pkg::CFG_DW-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> hw/rtl/swzd_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, product modulo 2^128.
module swzd_mul (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  swzd_pkg::mul_a_t a,
  input  swzd_pkg::mul_b_t b,
  output logic             busy,
  output swzd_pkg::mul_a_t prod
);
  swzd_pkg::mul_a_t a_r, acc_r;
  swzd_pkg::mul_b_t b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r <= '0;
    end else if (start) begin
      b_r <= b;
    end else if (b_r != '0) begin
      b_r <= b_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      acc_r <= '0;
    end else if (b_r != '0) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= a_r << 1;
    end
  end

  assign busy = (b_r != '0);
  assign prod = acc_r;
endmodule

>>> hw/rtl/swzd_dp.sv
// Datapath: window memory, running sums, sqrt/divide recurrences, decision and result register.
module swzd_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  swzd_pkg::dp_op_t      op,
  input  logic                  in_mode,
  input  logic signed [23:0]    in_sample,
  swzd_cfg_if.sink              cfg,
  swzd_out_if.source            out_ch,
  output swzd_pkg::dp_status_t  status
);
  // configuration
  logic [15:0] thr_r;
  logic [7:0]  wlen_r;
  logic        en_r;
  // window state
  logic [swzd_pkg::CNT_W-1:0]  count_r;
  logic [swzd_pkg::WIN_AW-1:0] ptr_r;
  logic signed [31:0]          sum_r;
  logic [53:0]                 sq_r;
  logic [31:0]                 evt_r, crit_r;
  logic [23:0]                 mem [swzd_pkg::WIN_MAX];
  // item working registers
  logic               mode_r;
  logic signed [23:0] x_r, old_r;
  logic [63:0]        d_r, sqd_r;
  logic [33:0]        rem_r;
  logic [31:0]        root_r, dq_r, a_r, t2_r;
  logic [7:0]         drem_r;
  logic [23:0]        std_r, mean_r;
  logic [95:0]        lhs_r, tgt_r;
  logic               warn_r, crit_flag_r;
  logic [15:0]        s_r;
  logic [33:0]        m_r;
  logic [67:0]        m2_r;
  logic [4:0]         iter_r;
  logic               out_valid_r;

  logic                 mul_start, mul_busy;
  swzd_pkg::mul_a_t     mul_a, mul_p;
  swzd_pkg::mul_b_t     mul_b;

  // derived values
  logic [7:0]  len;
  logic [15:0] teff;
  logic [17:0] t3;
  logic        full;
  logic [8:0]  pos_sum, pos_w;
  logic [7:0]  ptr_inc;
  logic [23:0] abs_x, abs_old;
  logic [31:0] abs_sum;
  logic [33:0] rem2, trial;
  logic [8:0]  dr2;
  logic        dbit;
  logic [15:0] cand;
  logic signed [33:0] nx, diff;
  logic [97:0] rhs4;
  logic        warn_c, crit_c, cfg_hit;

  always_comb begin
    len = (wlen_r == 8'd0) ? swzd_pkg::WLEN_DFLT : wlen_r;
    if (len > swzd_pkg::WLEN_CAP) len = swzd_pkg::WLEN_CAP;
  end

  assign teff    = (thr_r == 16'd0) ? swzd_pkg::THR_DFLT : thr_r;
  assign t3      = {1'b0, teff, 1'b0} + {2'b00, teff};
  assign full    = (count_r >= len);
  assign pos_sum = {2'b00, ptr_r} + {1'b0, count_r};
  assign pos_w   = (pos_sum >= {1'b0, len}) ? pos_sum - {1'b0, len} : pos_sum;
  assign ptr_inc = {1'b0, ptr_r} + 8'd1;
  assign abs_x   = x_r[23] ? 24'(-x_r) : 24'(x_r);
  assign abs_old = old_r[23] ? 24'(-old_r) : 24'(old_r);
  assign abs_sum = sum_r[31] ? 32'(-sum_r) : 32'(sum_r);
  assign rem2    = {rem_r[31:0], sqd_r[63:62]};
  assign trial   = {root_r, 2'b01};
  assign dr2     = {drem_r, dq_r[31]};
  assign dbit    = (dr2 >= {1'b0, count_r});
  assign cand    = s_r | (16'd1 << iter_r[3:0]);
  assign nx      = x_r[23] ? -$signed({2'b00, mul_p[31:0]}) : $signed({2'b00, mul_p[31:0]});
  assign diff    = nx - 34'(sum_r);
  assign rhs4    = {mul_p[95:0], 2'b00};
  assign warn_c  = ({2'b00, lhs_r} > {2'b00, mul_p[95:0]});
  assign crit_c  = ({2'b00, lhs_r} > rhs4);
  assign cfg_hit = cfg.valid && (cfg.index == swzd_pkg::CFG_THRESHOLD ||
                   cfg.index == swzd_pkg::CFG_WINDOW_LENGTH ||
                   cfg.index == swzd_pkg::CFG_DETECT_ENABLE);

  // multiplier operand select
  always_comb begin
    mul_start = 1'b1;
    mul_a     = '0;
    mul_b     = '0;
    unique case (op)
      swzd_pkg::OP_SUB_OLD: begin
        mul_a = swzd_pkg::mul_a_t'(abs_old); mul_b = swzd_pkg::mul_b_t'(abs_old);
      end
      swzd_pkg::OP_PUSH: begin
        mul_a = swzd_pkg::mul_a_t'(abs_x); mul_b = swzd_pkg::mul_b_t'(abs_x);
      end
      swzd_pkg::OP_MUL_NQ: begin
        mul_a = swzd_pkg::mul_a_t'(sq_r); mul_b = swzd_pkg::mul_b_t'(count_r);
      end
      swzd_pkg::OP_MUL_SS: begin
        mul_a = swzd_pkg::mul_a_t'(abs_sum); mul_b = swzd_pkg::mul_b_t'(abs_sum);
      end
      swzd_pkg::OP_MUL_NX: begin
        mul_a = swzd_pkg::mul_a_t'(abs_x); mul_b = swzd_pkg::mul_b_t'(count_r);
      end
      swzd_pkg::OP_MUL_AA: begin
        mul_a = swzd_pkg::mul_a_t'(a_r); mul_b = swzd_pkg::mul_b_t'(a_r);
      end
      swzd_pkg::OP_MUL_TT: begin
        mul_a = swzd_pkg::mul_a_t'(teff); mul_b = swzd_pkg::mul_b_t'(teff);
      end
      swzd_pkg::OP_MUL_DT: begin
        mul_a = swzd_pkg::mul_a_t'(d_r); mul_b = swzd_pkg::mul_b_t'(t2_r);
      end
      swzd_pkg::OP_MUL_M: begin
        mul_a = swzd_pkg::mul_a_t'(t3); mul_b = swzd_pkg::mul_b_t'(cand);
      end
      swzd_pkg::OP_MUL_MM: begin
        mul_a = swzd_pkg::mul_a_t'(m_r); mul_b = swzd_pkg::mul_b_t'(m_r);
      end
      swzd_pkg::OP_MUL_MD: begin
        mul_a = swzd_pkg::mul_a_t'(m2_r); mul_b = swzd_pkg::mul_b_t'(d_r);
      end
      default: mul_start = 1'b0;
    endcase
  end

  swzd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .prod  (mul_p)
  );

  // configuration and persistent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= swzd_pkg::THR_RESET;
      wlen_r      <= swzd_pkg::WLEN_RESET;
      en_r        <= 1'b1;
      count_r     <= '0;
      ptr_r       <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      evt_r       <= '0;
      crit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          swzd_pkg::CFG_THRESHOLD:     thr_r  <= cfg.data;
          swzd_pkg::CFG_WINDOW_LENGTH: wlen_r <= cfg.data[7:0];
          swzd_pkg::CFG_DETECT_ENABLE: en_r   <= cfg.data[0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        count_r <= '0;
        ptr_r   <= '0;
        sum_r   <= '0;
        sq_r    <= '0;
      end
      // a new result may load in the same cycle the held one transfers
      if (op == swzd_pkg::OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (op)
        swzd_pkg::OP_SUB_OLD: sum_r <= sum_r - 32'(old_r);
        swzd_pkg::OP_QSUB:    sq_r  <= sq_r - mul_p[53:0];
        swzd_pkg::OP_QADD:    sq_r  <= sq_r + mul_p[53:0];
        swzd_pkg::OP_PUSH: begin
          sum_r <= sum_r + 32'(x_r);
          if (!full) begin
            count_r <= count_r + 8'd1;
          end else begin
            ptr_r <= (ptr_inc == len) ? '0 : ptr_inc[swzd_pkg::WIN_AW-1:0];
          end
        end
        swzd_pkg::OP_R_SET: begin
          if (warn_c) begin
            evt_r <= evt_r + 32'd1;
            if (crit_c) crit_r <= crit_r + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // window memory
  always_ff @(posedge clk) begin
    if (op == swzd_pkg::OP_RD_OLD) old_r <= mem[ptr_r];
    if (op == swzd_pkg::OP_PUSH) begin
      if (full) mem[ptr_r] <= x_r;
      else      mem[pos_w[swzd_pkg::WIN_AW-1:0]] <= x_r;
    end
  end

  // per-item arithmetic
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= '0;
    end else begin
      unique case (op) inside
        swzd_pkg::OP_SQ_INIT, swzd_pkg::OP_DIV_STD_INIT,
        swzd_pkg::OP_DIV_MEAN_INIT:                  iter_r <= 5'd31;
        swzd_pkg::OP_SC_INIT:                        iter_r <= 5'd15;
        swzd_pkg::OP_SQ_STEP, swzd_pkg::OP_DIV_STEP,
        swzd_pkg::OP_SC_STEP:                        iter_r <= iter_r - 5'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      swzd_pkg::OP_LATCH: begin
        mode_r      <= in_mode;
        x_r         <= in_sample;
        d_r         <= '0;
        mean_r      <= '0;
        std_r       <= '0;
        warn_r      <= 1'b0;
        crit_flag_r <= 1'b0;
        s_r         <= '0;
      end
      swzd_pkg::OP_D_SET: d_r <= mul_p[63:0];
      swzd_pkg::OP_D_SUB: d_r <= d_r - mul_p[63:0];
      swzd_pkg::OP_SQ_INIT: begin
        sqd_r  <= d_r;
        rem_r  <= '0;
        root_r <= '0;
      end
      swzd_pkg::OP_SQ_STEP: begin
        sqd_r <= sqd_r << 2;
        if (rem2 >= trial) begin
          rem_r  <= rem2 - trial;
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          rem_r  <= rem2;
          root_r <= {root_r[30:0], 1'b0};
        end
      end
      swzd_pkg::OP_DIV_STD_INIT: begin
        dq_r   <= root_r;
        drem_r <= '0;
      end
      swzd_pkg::OP_DIV_MEAN_INIT: begin
        dq_r   <= abs_sum;
        drem_r <= '0;
      end
      swzd_pkg::OP_DIV_STEP: begin
        dq_r   <= {dq_r[30:0], dbit};
        drem_r <= dbit ? 8'(dr2 - {1'b0, count_r}) : dr2[7:0];
      end
      swzd_pkg::OP_STD_SET:  std_r  <= dq_r[23:0];
      swzd_pkg::OP_MEAN_SET: mean_r <= sum_r[31] ? 24'(-dq_r) : dq_r[23:0];
      swzd_pkg::OP_A_SET:    a_r    <= diff[33] ? 32'(-diff) : diff[31:0];
      swzd_pkg::OP_L_SET: begin
        lhs_r <= {16'd0, mul_p[63:0], 16'd0};
        tgt_r <= {mul_p[63:0], 32'd0};
      end
      swzd_pkg::OP_T2_SET: t2_r <= mul_p[31:0];
      swzd_pkg::OP_R_SET: begin
        warn_r      <= warn_c;
        crit_flag_r <= crit_c;
      end
      swzd_pkg::OP_M_SET:  m_r  <= mul_p[33:0];
      swzd_pkg::OP_M2_SET: m2_r <= mul_p[67:0];
      swzd_pkg::OP_SC_STEP: begin
        if (mul_p <= {32'd0, tgt_r}) s_r <= cand;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (op == swzd_pkg::OP_OUT) begin
      out_ch.anomaly    <= warn_r;
      out_ch.severity   <= !warn_r ? swzd_pkg::SEV_NONE :
                           crit_flag_r ? swzd_pkg::SEV_CRITICAL : swzd_pkg::SEV_WARNING;
      out_ch.evt_id     <= warn_r ? evt_r : 32'd0;
      out_ch.score      <= warn_r ? s_r : 16'd0;
      out_ch.mean       <= mean_r;
      out_ch.std_dev    <= std_r;
      out_ch.fill       <= count_r;
      out_ch.evt_total  <= evt_r;
      out_ch.crit_total <= crit_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign cfg.ready    = 1'b1;

  assign status.mul_busy  = mul_busy;
  assign status.mode      = mode_r;
  assign status.full      = full;
  assign status.n_zero    = (count_r == '0);
  assign status.ev_cand   = mode_r && en_r && (d_r != '0);
  assign status.warn      = warn_r;
  assign status.iter_last = (iter_r == 5'd0);
  assign status.out_free  = !out_valid_r || out_ch.ready;
endmodule

>>> hw/rtl/swzd_ctrl.sv
// Controller: sequences the datapath through push, statistics, decision and score steps.
module swzd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  swzd_pkg::dp_status_t status,
  output logic                 in_ready,
  output swzd_pkg::dp_op_t     op
);
  swzd_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= swzd_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swzd_pkg::S_IDLE:  if (in_valid) state_nxt = swzd_pkg::S_DISP;
      swzd_pkg::S_DISP:  state_nxt = status.mode ? swzd_pkg::S_STATS :
                                     status.full ? swzd_pkg::S_RD : swzd_pkg::S_PUSH;
      swzd_pkg::S_RD:    state_nxt = swzd_pkg::S_OLD;
      swzd_pkg::S_OLD:   state_nxt = swzd_pkg::S_OLDW;
      swzd_pkg::S_OLDW:  if (!status.mul_busy) state_nxt = swzd_pkg::S_PUSH;
      swzd_pkg::S_PUSH:  state_nxt = swzd_pkg::S_PUSHW;
      swzd_pkg::S_PUSHW: if (!status.mul_busy) state_nxt = swzd_pkg::S_STATS;
      swzd_pkg::S_STATS: state_nxt = status.n_zero ? swzd_pkg::S_FIN : swzd_pkg::S_NQW;
      swzd_pkg::S_NQW:   if (!status.mul_busy) state_nxt = swzd_pkg::S_SS;
      swzd_pkg::S_SS:    state_nxt = swzd_pkg::S_SSW;
      swzd_pkg::S_SSW:   if (!status.mul_busy) state_nxt = swzd_pkg::S_SQI;
      swzd_pkg::S_SQI:   state_nxt = swzd_pkg::S_SQ;
      swzd_pkg::S_SQ:    if (status.iter_last) state_nxt = swzd_pkg::S_DVI;
      swzd_pkg::S_DVI:   state_nxt = swzd_pkg::S_DVS;
      swzd_pkg::S_DVS:   if (status.iter_last) state_nxt = swzd_pkg::S_STD;
      swzd_pkg::S_STD:   state_nxt = swzd_pkg::S_DVM;
      swzd_pkg::S_DVM:   state_nxt = swzd_pkg::S_DVMS;
      swzd_pkg::S_DVMS:  if (status.iter_last) state_nxt = swzd_pkg::S_MEAN;
      swzd_pkg::S_MEAN:  state_nxt = status.ev_cand ? swzd_pkg::S_NX : swzd_pkg::S_FIN;
      swzd_pkg::S_NX:    state_nxt = swzd_pkg::S_NXW;
      swzd_pkg::S_NXW:   if (!status.mul_busy) state_nxt = swzd_pkg::S_AA;
      swzd_pkg::S_AA:    state_nxt = swzd_pkg::S_AAW;
      swzd_pkg::S_AAW:   if (!status.mul_busy) state_nxt = swzd_pkg::S_TT;
      swzd_pkg::S_TT:    state_nxt = swzd_pkg::S_TTW;
      swzd_pkg::S_TTW:   if (!status.mul_busy) state_nxt = swzd_pkg::S_DT;
      swzd_pkg::S_DT:    state_nxt = swzd_pkg::S_DTW;
      swzd_pkg::S_DTW:   if (!status.mul_busy) state_nxt = swzd_pkg::S_DEC;
      swzd_pkg::S_DEC:   state_nxt = status.warn ? swzd_pkg::S_SCI : swzd_pkg::S_FIN;
      swzd_pkg::S_SCI:   state_nxt = swzd_pkg::S_M;
      swzd_pkg::S_M:     state_nxt = swzd_pkg::S_MW;
      swzd_pkg::S_MW:    if (!status.mul_busy) state_nxt = swzd_pkg::S_MM;
      swzd_pkg::S_MM:    state_nxt = swzd_pkg::S_MMW;
      swzd_pkg::S_MMW:   if (!status.mul_busy) state_nxt = swzd_pkg::S_MD;
      swzd_pkg::S_MD:    state_nxt = swzd_pkg::S_MDW;
      swzd_pkg::S_MDW: begin
        if (!status.mul_busy) begin
          state_nxt = status.iter_last ? swzd_pkg::S_FIN : swzd_pkg::S_M;
        end
      end
      swzd_pkg::S_FIN:   if (status.out_free) state_nxt = swzd_pkg::S_IDLE;
      default:           state_nxt = swzd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    op       = swzd_pkg::OP_NOP;
    unique case (state_r)
      swzd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = swzd_pkg::OP_LATCH;
      end
      swzd_pkg::S_RD:    op = swzd_pkg::OP_RD_OLD;
      swzd_pkg::S_OLD:   op = swzd_pkg::OP_SUB_OLD;
      swzd_pkg::S_OLDW:  if (!status.mul_busy) op = swzd_pkg::OP_QSUB;
      swzd_pkg::S_PUSH:  op = swzd_pkg::OP_PUSH;
      swzd_pkg::S_PUSHW: if (!status.mul_busy) op = swzd_pkg::OP_QADD;
      swzd_pkg::S_STATS: if (!status.n_zero) op = swzd_pkg::OP_MUL_NQ;
      swzd_pkg::S_NQW:   if (!status.mul_busy) op = swzd_pkg::OP_D_SET;
      swzd_pkg::S_SS:    op = swzd_pkg::OP_MUL_SS;
      swzd_pkg::S_SSW:   if (!status.mul_busy) op = swzd_pkg::OP_D_SUB;
      swzd_pkg::S_SQI:   op = swzd_pkg::OP_SQ_INIT;
      swzd_pkg::S_SQ:    op = swzd_pkg::OP_SQ_STEP;
      swzd_pkg::S_DVI:   op = swzd_pkg::OP_DIV_STD_INIT;
      swzd_pkg::S_DVS:   op = swzd_pkg::OP_DIV_STEP;
      swzd_pkg::S_STD:   op = swzd_pkg::OP_STD_SET;
      swzd_pkg::S_DVM:   op = swzd_pkg::OP_DIV_MEAN_INIT;
      swzd_pkg::S_DVMS:  op = swzd_pkg::OP_DIV_STEP;
      swzd_pkg::S_MEAN:  op = swzd_pkg::OP_MEAN_SET;
      swzd_pkg::S_NX:    op = swzd_pkg::OP_MUL_NX;
      swzd_pkg::S_NXW:   if (!status.mul_busy) op = swzd_pkg::OP_A_SET;
      swzd_pkg::S_AA:    op = swzd_pkg::OP_MUL_AA;
      swzd_pkg::S_AAW:   if (!status.mul_busy) op = swzd_pkg::OP_L_SET;
      swzd_pkg::S_TT:    op = swzd_pkg::OP_MUL_TT;
      swzd_pkg::S_TTW:   if (!status.mul_busy) op = swzd_pkg::OP_T2_SET;
      swzd_pkg::S_DT:    op = swzd_pkg::OP_MUL_DT;
      swzd_pkg::S_DTW:   if (!status.mul_busy) op = swzd_pkg::OP_R_SET;
      swzd_pkg::S_SCI:   op = swzd_pkg::OP_SC_INIT;
      swzd_pkg::S_M:     op = swzd_pkg::OP_MUL_M;
      swzd_pkg::S_MW:    if (!status.mul_busy) op = swzd_pkg::OP_M_SET;
      swzd_pkg::S_MM:    op = swzd_pkg::OP_MUL_MM;
      swzd_pkg::S_MMW:   if (!status.mul_busy) op = swzd_pkg::OP_M2_SET;
      swzd_pkg::S_MD:    op = swzd_pkg::OP_MUL_MD;
      swzd_pkg::S_MDW:   if (!status.mul_busy) op = swzd_pkg::OP_SC_STEP;
      swzd_pkg::S_FIN:   if (status.out_free) op = swzd_pkg::OP_OUT;
      default:           op = swzd_pkg::OP_NOP;
    endcase
  end
endmodule

>>> hw/rtl/sliding_window_zscore_detector_top.sv
// Top level of the sliding-window z-score detector: controller, datapath and channels.
// One item is in work at a time; in_ch.ready is high only while the controller is idle.
// Cycle cost is set by the shared shift-add multiplier (one multiplier bit per cycle),
// a 32-step square-root recurrence and two 32-step restoring divides by the fill count.
// An add item takes longer once the window is full, as it retires the oldest sample; a
// detect item skips the statistics on an empty window, and a detect item that raises an
// event adds a 16-step score search. The result sits in an output register; the next
// item is accepted while it waits, and that item's result is loaded once the previous
// one has transferred.
// Any configuration write to a listed register empties the window; event counters persist.
module sliding_window_zscore_detector_top (
  input  logic       clk,
  input  logic       rst_n,
  swzd_in_if.sink    in_ch,
  swzd_out_if.source out_ch,
  swzd_cfg_if.sink   cfg_ch
);
  swzd_pkg::dp_op_t     op;
  swzd_pkg::dp_status_t status;
  logic                 in_ready;

  assign in_ch.ready = in_ready;

  // sequencing only; all arithmetic and state live in the datapath
  swzd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .status   (status),
    .in_ready (in_ready),
    .op       (op)
  );

  swzd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_mode   (in_ch.mode),
    .in_sample (in_ch.sample),
    .cfg       (cfg_ch),
    .out_ch    (out_ch),
    .status    (status)
  );
endmodule

>>> hw/rtl/swzd_checker.sv
// Port-level checker for the detector, bound to the top level.
module swzd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        anomaly,
  input logic [1:0]  severity,
  input logic [31:0] evt_id,
  input logic [15:0] score,
  input logic [7:0]  fill
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(evt_id) && $stable(score) && $stable(fill))
    else $error("stalled result changed");

  a_sev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (anomaly == (severity != swzd_pkg::SEV_NONE))
                  && (severity <= swzd_pkg::SEV_CRITICAL))
    else $error("severity inconsistent with anomaly");

  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !anomaly |-> (evt_id == 32'd0) && (score == 16'd0)
                              && (fill <= swzd_pkg::WLEN_CAP))
    else $error("non-event result carries event fields");
endmodule

bind sliding_window_zscore_detector_top swzd_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .anomaly   (out_ch.anomaly),
  .severity  (out_ch.severity),
  .evt_id    (out_ch.evt_id),
  .score     (out_ch.score),
  .fill      (out_ch.fill)
);
